[rtl/tcce_pkg.sv]
package tcce_pkg;

   // Default screen geometry.
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // Port field widths.
   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int ADDR_W   = 11;
   localparam int CELL_W   = 16;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int ATTR_W   = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [ATTR_W-1:0] attr_type;

   // Commands.
   localparam cmd_type CMD_PUT   = 2'd0;
   localparam cmd_type CMD_CLEAR = 2'd1;
   localparam cmd_type CMD_READ  = 2'd2;

   // Character codes with special handling.
   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_BS    = 8'h08;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_NL    = 8'h0A;
   localparam char_type CH_CR    = 8'h0D;
   localparam char_type CH_SPACE = 8'h20;

   localparam attr_type ATTR_RESET = 8'h07;
   localparam cell_type BLANK_CELL = 16'h0720;

endpackage

[rtl/text_console_cursor_engine.sv]
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid / req_tready   tuser: command; tdata: char_code, cell_address
// rsp      out        rsp_tvalid / rsp_tready   tdata: cell_value, cursor_row, cursor_col
// csr      in         csr_wr_en                 csr_wr_data: text_attribute
//
// One transaction is worked at a time; the character store takes one write per cycle.
// Plain characters, controls and unused commands finish when accepted; reads use S_READ, tabs S_FILL.
// Clear walks all ROWS*COLUMNS cells, one per cycle, after the accepting cycle.
// A newline, tab or character that wraps off the last row scrolls the screen up by one row.
// After reset a clearing pass over all ROWS*COLUMNS cells holds req_tready low.
// The result sits in an output register, so a new transaction can be taken as it leaves.
module text_console_cursor_engine #(
   parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // char_code [7:0], cell_address [18:8], zero [23:19]
   input  logic [tcce_pkg::REQ_DATA_W-1:0]      req_tdata,
   // command [1:0]
   input  tcce_pkg::cmd_type                    req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // cell_value [15:0], cursor_row [20:16], cursor_col [27:21], zero [31:28]
   output logic [tcce_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_wr_en,
   input  tcce_pkg::attr_type                   csr_wr_data
);

   import tcce_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int AXW   = (AW > ADDR_W) ? AW : ADDR_W;
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS + 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_POST   = 3'd4;
   localparam logic [2:0] S_FILL   = 3'd5;

   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_END  = CW'(COLUMNS);
   localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
   localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
   localparam logic [AXW:0]  CELL_COUNT = (AXW + 1)'(CELLS);

   logic [2:0]      state_ff, state_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   attr_type        attr_ff, attr_in;
   char_type        char_ff, char_in;
   logic            resp_pend_ff, resp_pend_in;
   logic            rd_ok_ff, rd_ok_in;
   logic [2:0]      fill_n_ff, fill_n_in;
   logic [AW-1:0]   sweep_ff, sweep_in;
   logic            issue_done_ff, issue_done_in;
   logic            pipe_vld_ff, pipe_vld_in;
   logic [AW-1:0]   pipe_addr_ff, pipe_addr_in;
   logic            pipe_copy_ff, pipe_copy_in;
   logic            pipe_last_ff, pipe_last_in;
   logic            rsp_vld_ff, rsp_vld_in;
   cell_type        rsp_value_ff, rsp_value_in;
   logic [RW-1:0]   rsp_row_ff, rsp_row_in;
   logic [CW-1:0]   rsp_col_ff, rsp_col_in;

   logic            accept;
   cmd_type         req_cmd;
   char_type        req_char;
   logic [AXW-1:0]  req_addr;
   logic            load_rsp;
   cell_type        load_value;
   logic            pos_write;
   logic [RW-1:0]   w_row;
   logic [CW-1:0]   w_col;
   logic [AW-1:0]   pos_addr;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [AW-1:0]   lin_waddr;
   cell_type        mem_wdata;
   logic [AW-1:0]   mem_raddr;
   cell_type        mem_rdata;
   cell_type        blank_cur;
   logic [31:0]     row_wide;
   logic [31:0]     col_wide;

   assign req_cmd   = req_tuser;
   assign req_char  = req_tdata[7:0];
   assign req_addr  = AXW'(req_tdata[18:8]);
   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && (!rsp_vld_ff || rsp_tready);
   assign blank_cur = {attr_ff, CH_SPACE};
   assign pos_addr  = AW'(w_row) * AW'(COLUMNS) + AW'(w_col);
   assign mem_waddr = pos_write ? pos_addr : lin_waddr;

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      char_in       = char_ff;
      resp_pend_in  = resp_pend_ff;
      rd_ok_in      = rd_ok_ff;
      fill_n_in     = fill_n_ff;
      sweep_in      = sweep_ff;
      issue_done_in = issue_done_ff;
      pipe_vld_in   = 1'b0;
      pipe_addr_in  = pipe_addr_ff;
      pipe_copy_in  = pipe_copy_ff;
      pipe_last_in  = pipe_last_ff;
      load_rsp      = 1'b0;
      load_value    = '0;
      pos_write     = 1'b0;
      w_row         = row_ff;
      w_col         = col_ff;
      mem_we        = 1'b0;
      lin_waddr     = sweep_ff;
      mem_wdata     = blank_cur;
      mem_raddr     = req_addr[AW-1:0];

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = BLANK_CELL;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == CELL_LAST) begin
               state_in     = S_IDLE;
               load_rsp     = resp_pend_ff;
               resp_pend_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               char_in = req_char;
               case (req_cmd)
                  CMD_PUT: begin
                     case (req_char)
                        CH_NUL: begin
                           load_rsp = 1'b1;
                        end
                        CH_CR: begin
                           col_in   = '0;
                           load_rsp = 1'b1;
                        end
                        CH_NL: begin
                           col_in = '0;
                           if (row_ff != LAST_ROW) begin
                              row_in   = row_ff + RW'(1);
                              load_rsp = 1'b1;
                           end else begin
                              state_in      = S_SCROLL;
                              sweep_in      = '0;
                              issue_done_in = 1'b0;
                           end
                        end
                        CH_BS: begin
                           if (col_ff == '0 && row_ff == '0) begin
                              load_rsp = 1'b1;
                           end else begin
                              if (col_ff == '0) begin
                                 row_in = row_ff - RW'(1);
                                 col_in = COL_LAST;
                              end else begin
                                 col_in = col_ff - CW'(1);
                              end
                              w_row     = row_in;
                              w_col     = col_in;
                              pos_write = 1'b1;
                              mem_we    = 1'b1;
                              load_rsp  = 1'b1;
                           end
                        end
                        CH_TAB: begin
                           if (col_ff == COL_END) begin
                              col_in = '0;
                              if (row_ff != LAST_ROW) begin
                                 row_in    = row_ff + RW'(1);
                                 fill_n_in = 3'd4;
                                 state_in  = S_FILL;
                              end else begin
                                 state_in      = S_SCROLL;
                                 sweep_in      = '0;
                                 issue_done_in = 1'b0;
                              end
                           end else begin
                              fill_n_in = 3'd4 - {1'b0, col_ff[1:0]};
                              state_in  = S_FILL;
                           end
                        end
                        default: begin
                           mem_wdata = {attr_ff, req_char};
                           if (col_ff == COL_END) begin
                              col_in = '0;
                              if (row_ff != LAST_ROW) begin
                                 row_in    = row_ff + RW'(1);
                                 col_in    = CW'(1);
                                 w_row     = row_in;
                                 w_col     = '0;
                                 pos_write = 1'b1;
                                 mem_we    = 1'b1;
                                 load_rsp  = 1'b1;
                              end else begin
                                 state_in      = S_SCROLL;
                                 sweep_in      = '0;
                                 issue_done_in = 1'b0;
                              end
                           end else begin
                              col_in    = col_ff + CW'(1);
                              pos_write = 1'b1;
                              mem_we    = 1'b1;
                              load_rsp  = 1'b1;
                           end
                        end
                     endcase
                  end
                  CMD_CLEAR: begin
                     row_in       = '0;
                     col_in       = '0;
                     sweep_in     = '0;
                     resp_pend_in = 1'b1;
                     state_in     = S_CLEAR;
                  end
                  CMD_READ: begin
                     rd_ok_in = {1'b0, req_addr} < CELL_COUNT;
                     state_in = S_READ;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            load_rsp   = 1'b1;
            load_value = rd_ok_ff ? mem_rdata : '0;
            state_in   = S_IDLE;
         end
         S_SCROLL: begin
            // Reads fetch the cell one row below the issue pointer, which runs one cell ahead of the
            // write-back; a read address never falls below the current write address, so no forwarding is needed.
            mem_raddr = sweep_ff + AW'(COLUMNS);
            if (!issue_done_ff) begin
               pipe_vld_in   = 1'b1;
               pipe_addr_in  = sweep_ff;
               pipe_copy_in  = sweep_ff < COPY_END;
               pipe_last_in  = sweep_ff == CELL_LAST;
               issue_done_in = sweep_ff == CELL_LAST;
               sweep_in      = sweep_ff + AW'(1);
            end
            if (pipe_vld_ff) begin
               mem_we    = 1'b1;
               lin_waddr = pipe_addr_ff;
               mem_wdata = pipe_copy_ff ? mem_rdata : blank_cur;
               if (pipe_last_ff) begin
                  state_in = S_POST;
               end
            end
         end
         S_POST: begin
            col_in   = '0;
            state_in = S_IDLE;
            case (char_ff)
               CH_NL: begin
                  load_rsp = 1'b1;
               end
               CH_TAB: begin
                  fill_n_in = 3'd4;
                  state_in  = S_FILL;
               end
               default: begin
                  mem_wdata = {attr_ff, char_ff};
                  w_col     = '0;
                  pos_write = 1'b1;
                  mem_we    = 1'b1;
                  col_in    = CW'(1);
                  load_rsp  = 1'b1;
               end
            endcase
         end
         S_FILL: begin
            pos_write = 1'b1;
            mem_we    = 1'b1;
            col_in    = col_ff + CW'(1);
            fill_n_in = fill_n_ff - 3'd1;
            if (fill_n_ff == 3'd1 || col_ff == COL_LAST) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      attr_in = attr_ff;
      if (csr_wr_en) begin
         attr_in = csr_wr_data;
      end
      if (accept && req_cmd == CMD_CLEAR) begin
         attr_in = ATTR_RESET;
      end
   end

   always_comb begin
      rsp_vld_in   = rsp_vld_ff;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      if (load_rsp) begin
         rsp_vld_in   = 1'b1;
         rsp_value_in = load_value;
         rsp_row_in   = row_in;
         rsp_col_in   = col_in;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         row_ff        <= '0;
         col_ff        <= '0;
         attr_ff       <= ATTR_RESET;
         resp_pend_ff  <= 1'b0;
         sweep_ff      <= '0;
         issue_done_ff <= 1'b0;
         pipe_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         attr_ff       <= attr_in;
         resp_pend_ff  <= resp_pend_in;
         sweep_ff      <= sweep_in;
         issue_done_ff <= issue_done_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      rd_ok_ff     <= rd_ok_in;
      fill_n_ff    <= fill_n_in;
      pipe_addr_ff <= pipe_addr_in;
      pipe_copy_ff <= pipe_copy_in;
      pipe_last_ff <= pipe_last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign row_wide   = 32'(rsp_row_ff);
   assign col_wide   = 32'(rsp_col_ff);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0, col_wide[COL_W-1:0], row_wide[ROW_W-1:0], rsp_value_ff};

   // A new transaction must never overwrite a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!rsp_vld_ff || rsp_tready))
      else $error("request accepted while a result is still held");

   // The cursor stays on the screen, with at most the pending-wrap column.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= LAST_ROW) && (col_ff <= COL_END))
      else $error("cursor left the screen");

   // Scrolling only happens from the bottom row.
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL) |-> (row_ff == LAST_ROW))
      else $error("scroll started away from the last row");

   // Every store write lands inside the screen.
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr <= CELL_LAST))
      else $error("store write beyond the last cell");

endmodule

[rtl/tcce_ram.sv]
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/tcce_console_checker.sv]
`timescale 1ns / 100ps

module tcce_console_checker #(
   parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [tcce_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  tcce_pkg::cmd_type                 req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [tcce_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wr_en,
   input  tcce_pkg::attr_type                csr_wr_data,
   output int                                failures,
   output int                                outstanding
);
   import tcce_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      cell_type         cell_value;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } cursor_report_type;

   cell_type          screen [CELLS];
   int unsigned       row_now;
   int unsigned       col_now;
   attr_type          attr_now;
   cursor_report_type cursor_reports [$];
   int                fault_count = 0;
   int                pending_count = 0;

   assign failures    = fault_count;
   assign outstanding = pending_count;

   function void blank_screen();
      for (int i = 0; i < CELLS; i++) begin
         screen[i] = BLANK_CELL;
      end
      row_now  = 0;
      col_now  = 0;
      attr_now = ATTR_RESET;
   endfunction

   function void write_cell(int unsigned r, int unsigned c, char_type ch);
      if (r < ROWS && c < COLUMNS) begin
         screen[r * COLUMNS + c] = {attr_now, ch};
      end
   endfunction

   // A line feed on the bottom row shifts everything up and blanks the
   // bottom row in the current attribute.
   function void line_feed();
      if (row_now < ROWS - 1) begin
         row_now++;
      end else begin
         for (int i = 0; i + COLUMNS < CELLS; i++) begin
            screen[i] = screen[i + COLUMNS];
         end
         for (int c = 0; c < COLUMNS; c++) begin
            write_cell(ROWS - 1, c, CH_SPACE);
         end
      end
      col_now = 0;
   endfunction

   function void put_char(char_type ch);
      int unsigned fill;
      case (ch)
         CH_NUL: begin
         end
         CH_NL: begin
            line_feed();
         end
         CH_CR: begin
            col_now = 0;
         end
         CH_BS: begin
            if (col_now != 0 || row_now != 0) begin
               if (col_now == 0) begin
                  row_now--;
                  col_now = COLUMNS;
               end
               col_now--;
               write_cell(row_now, col_now, CH_SPACE);
            end
         end
         CH_TAB: begin
            if (col_now >= COLUMNS) begin
               line_feed();
            end
            fill = 4 - (col_now % 4);
            while (fill != 0 && col_now < COLUMNS) begin
               write_cell(row_now, col_now, CH_SPACE);
               col_now++;
               fill--;
            end
         end
         default: begin
            // Column COLUMNS means the wrap is still pending.
            if (col_now >= COLUMNS) begin
               line_feed();
            end
            write_cell(row_now, col_now, ch);
            col_now++;
         end
      endcase
   endfunction

   function cursor_report_type console_step(cmd_type cmd, char_type ch,
                                            logic [ADDR_W-1:0] addr);
      cursor_report_type rep;
      rep = '0;
      case (cmd)
         CMD_PUT:   put_char(ch);
         CMD_CLEAR: blank_screen();
         CMD_READ: begin
            if (addr < CELLS) begin
               rep.cell_value = screen[addr];
            end
         end
         default: begin
         end
      endcase
      rep.row = ROW_W'(row_now);
      rep.col = COL_W'(col_now);
      return rep;
   endfunction

   always @(posedge clock) begin
      cursor_report_type got;
      cursor_report_type want;
      if (reset) begin
         blank_screen();
         cursor_reports.delete();
      end else begin
         if (csr_wr_en) begin
            attr_now = csr_wr_data;
         end
         // The response is registered, so it never belongs to a request
         // taken at the same edge; check it before queuing a new one.
         if (rsp_tvalid && rsp_tready) begin
            got.cell_value = rsp_tdata[CELL_W-1:0];
            got.row        = rsp_tdata[CELL_W +: ROW_W];
            got.col        = rsp_tdata[CELL_W + ROW_W +: COL_W];
            if (cursor_reports.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("[%0t] unexpected response: value %h row %0d col %0d",
                           $time, got.cell_value, got.row, got.col);
               end
            end else begin
               want = cursor_reports.pop_front();
               if (got.cell_value !== want.cell_value || got.row !== want.row ||
                   got.col !== want.col) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("[%0t] mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                              $time, want.cell_value, want.row, want.col,
                              got.cell_value, got.row, got.col);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            cursor_reports.push_back(console_step(req_tuser, req_tdata[CHAR_W-1:0],
                                                  req_tdata[CHAR_W +: ADDR_W]));
         end
      end
      pending_count <= cursor_reports.size();
   end

endmodule

[verif/tb_text_console_cursor_engine.sv]
`timescale 1ns / 100ps

module tb_text_console_cursor_engine;
   import tcce_pkg::*;

   localparam int      COLUMNS      = COLUMNS_DEFAULT;
   localparam int      ROWS         = ROWS_DEFAULT;
   localparam int      CELLS        = COLUMNS * ROWS;
   localparam int      ADDR_SPAN    = 1 << ADDR_W;
   localparam cmd_type CMD_UNUSED   = 2'd3;
   localparam int      RANDOM_ITEMS = 2000;
   localparam int      PHASES       = 6;
   localparam int      QUIET_LIMIT  = 20000;
   localparam int      DRAIN_CYCLES = 16;
   localparam int      HOLD_CYCLES  = 600;
   localparam int      HOLD_AFTER   = 150;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef enum int {STALL_NONE, STALL_HALF, STALL_MOST, STALL_TOGGLE} stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   cmd_type               req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en;
   attr_type              csr_wr_data;
   int                    failures;
   int                    outstanding;
   int                    items_sent = 0;
   int                    burst_left = 0;
   int                    quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_cursor_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tcce_console_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("text_console_cursor_engine regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic addr_type rand_addr();
      return addr_type'($urandom);
   endfunction

   function automatic char_type printable_char();
      return char_type'($urandom_range(8'h20, 8'h7E));
   endfunction

   function automatic char_type control_char();
      case ($urandom_range(0, 3))
         0:       return CH_NL;
         1:       return CH_CR;
         2:       return CH_BS;
         default: return CH_TAB;
      endcase
   endfunction

   function automatic char_type text_char();
      int roll = $urandom_range(0, 99);
      if (roll < 85) begin
         return printable_char();
      end else if (roll < 95) begin
         return control_char();
      end
      return char_type'($urandom);
   endfunction

   // Offers one transaction and holds it until taken. Valid stays high
   // across a burst and drops only for the gap that follows it.
   task automatic send_item(input cmd_type cmd, input char_type ch, input addr_type addr);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'({addr, ch});
      do @(posedge clock); while (!req_tready);
      if (!(cmd == CMD_UNUSED || (cmd == CMD_PUT && ch == CH_NUL))) begin
         items_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic put_char(input char_type ch);
      send_item(CMD_PUT, ch, rand_addr());
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_attribute(input attr_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_sequence();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 33) begin
         repeat ($urandom_range(1, 24)) put_char(text_char());
      end else if (pick < 45) begin
         // Tab to the last tab stop or the end of the row, then act on any pending wrap.
         put_char(CH_CR);
         repeat ($urandom_range(19, 20)) put_char(CH_TAB);
         if ($urandom_range(0, 3) == 0) begin
            put_char(printable_char());
         end else begin
            put_char(control_char());
         end
      end else if (pick < 55) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 28) : $urandom_range(1, 4);
         repeat (len) put_char(CH_NL);
      end else if (pick < 70) begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 7) == 0) begin
               send_item(CMD_READ, char_type'($urandom),
                         addr_type'($urandom_range(CELLS, ADDR_SPAN - 1)));
            end else begin
               send_item(CMD_READ, char_type'($urandom),
                         addr_type'($urandom_range(0, CELLS - 1)));
            end
         end
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 90)) put_char(CH_BS);
      end else if (pick < 86) begin
         // A row of text of COLUMNS-2 to COLUMNS+1 characters runs up to or past the deferred wrap.
         put_char(CH_CR);
         repeat ($urandom_range(COLUMNS - 2, COLUMNS + 1)) put_char(printable_char());
      end else if (pick < 91) begin
         case ($urandom_range(0, 2))
            0:       put_char(CH_NUL);
            1:       send_item(CMD_UNUSED, char_type'($urandom), rand_addr());
            default: put_char(CH_CR);
         endcase
      end else if (pick < 93) begin
         send_item(CMD_CLEAR, char_type'($urandom), rand_addr());
      end else begin
         send_item(cmd_type'($urandom_range(0, 3)), char_type'($urandom), rand_addr());
      end
   endtask

   // Receiver: random stall patterns, plus one long hold-off that backs
   // the engine up until it refuses new transactions.
   initial begin
      stall_mode_type mode;
      int             seen;
      bit             held;
      seen = 0;
      held = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         if (!held && seen >= HOLD_AFTER) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               if (rsp_tvalid && rsp_tready) seen++;
               rsp_tready <= 1'b0;
            end
         end
         mode = stall_mode_type'($urandom_range(0, 3));
         repeat ($urandom_range(4, 64)) begin
            @(posedge clock);
            if (rsp_tvalid && rsp_tready) seen++;
            case (mode)
               STALL_NONE: rsp_tready <= 1'b1;
               STALL_HALF: rsp_tready <= 1'($urandom_range(0, 1));
               STALL_MOST: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:    rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   initial begin
      int       base;
      attr_type attr;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_PUT;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed checks, with the attribute still at its reset value.
      send_item(CMD_READ, 8'h00, addr_type'(0));
      send_item(CMD_READ, 8'hFF, addr_type'(CELLS - 1));
      send_item(CMD_READ, 8'h00, addr_type'(CELLS));
      send_item(CMD_READ, 8'h00, addr_type'(ADDR_SPAN - 1));
      put_char(CH_BS);
      put_char(CH_NUL);
      send_item(CMD_UNUSED, 8'hFF, addr_type'(ADDR_SPAN - 1));
      put_char(8'h41);
      put_char(8'hFF);
      put_char(8'h01);
      put_char(CH_TAB);
      put_char(CH_TAB);
      put_char(CH_CR);
      put_char(CH_NL);
      // Backspace at column zero lands on the last cell of the row above.
      put_char(CH_BS);
      put_char(8'h5A);
      put_char(CH_BS);
      put_char(8'h5A);
      put_char(CH_TAB);
      send_item(CMD_READ, 8'h00, addr_type'(COLUMNS - 1));
      send_item(CMD_READ, 8'h00, addr_type'(COLUMNS));
      send_item(CMD_READ, 8'h00, addr_type'(1));
      send_item(CMD_CLEAR, 8'h00, addr_type'(0));
      send_item(CMD_READ, 8'h00, addr_type'(0));

      base = items_sent;
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p)
            0:       attr = 8'h00;
            1:       attr = 8'hFF;
            3:       attr = 8'h80;
            4:       attr = 8'h01;
            default: attr = attr_type'($urandom);
         endcase
         write_attribute(attr);
         // Run down to the bottom row so that scrolling is certain.
         if (p % 3 == 0) begin
            repeat (ROWS + 1) put_char(CH_NL);
         end
         while (items_sent < base + RANDOM_ITEMS * (p + 1) / PHASES) begin
            run_sequence();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("text_console_cursor_engine regression: pass");
      end else begin
         $display("text_console_cursor_engine regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/text_console_cursor_engine.sv
verif/tcce_console_checker.sv
verif/tb_text_console_cursor_engine.sv
